/* hw/rtl/ske_pkg.sv */
// ----------------------------------------------------------------------------
// Sampled k-mer extractor package
// Shared field widths, register indexes and the types passed between modules.
// ----------------------------------------------------------------------------
package ske_pkg;

    localparam int KLEN_W     = 5;
    localparam int WIN_W      = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int VALUE_W    = 62;
    localparam int OFFSET_W   = 48;
    localparam int SEEN_W     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WINDOW = 1'b1;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd15;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 10'd1;

    typedef struct packed {
        logic [KLEN_W-1:0] kmer_length;
        logic [WIN_W-1:0]  sample_window;
    } ske_cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  kmer_value;
        logic [OFFSET_W-1:0] kmer_offset;
    } ske_result_t;

endpackage

/* hw/rtl/sampled_kmer_extractor_top.sv */
// ----------------------------------------------------------------------------
// Sampled k-mer extractor
// Takes one 2-bit base per cycle while not stalled and emits every sampled
// k-mer with its global start offset. A base is registered on acceptance and
// processed once the result queue has room: the window state is updated and a
// sampled k-mer is written to a two-entry result queue, whose head drives the
// outputs. The block sustains one base per cycle; input requests stall only
// while the result queue is full.
// ----------------------------------------------------------------------------
module sampled_kmer_extractor_top #(
    parameter int MAX_KMER_LENGTH = 31,
    parameter int POSITION_BITS   = 48,
    parameter int WINDOW_BITS     = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ske_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ske_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        base_code,
    input  logic                              last_base,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ske_pkg::VALUE_W-1:0]       kmer_value,
    output logic [ske_pkg::OFFSET_W-1:0]      kmer_offset
);
    import ske_pkg::*;

    ske_cfg_t    cfg_reg;
    ske_result_t core_result;
    ske_result_t out_data;
    logic        core_push;
    logic        buf_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kmer_length   <= KLEN_RESET;
            cfg_reg.sample_window <= WIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_KMER_LENGTH:   cfg_reg.kmer_length   <= cfg_data[KLEN_W-1:0];
                REG_SAMPLE_WINDOW: cfg_reg.sample_window <= cfg_data[WIN_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    ske_core #(
        .MAX_KMER_LENGTH (MAX_KMER_LENGTH),
        .POSITION_BITS   (POSITION_BITS),
        .WINDOW_BITS     (WINDOW_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base_code (base_code),
        .last_base (last_base),
        .buf_ready (buf_ready),
        .push      (core_push),
        .result    (core_result)
    );

    ske_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_push),
        .push_data (core_result),
        .buf_ready (buf_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kmer_value  = out_data.kmer_value;
    assign kmer_offset = out_data.kmer_offset;

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        core_push |-> buf_ready)
        else $error("result pushed into a full queue");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !buf_ready)
        else $error("input stalled while the result queue has room");

    a_result_leaves_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("queued result dropped without being taken");
`endif

endmodule

/* hw/rtl/ske_core.sv */
// ----------------------------------------------------------------------------
// Sampled k-mer extractor core
// Input register, per-sequence window state and the sampling decision.
// ----------------------------------------------------------------------------
module ske_core #(
    parameter int MAX_KMER_LENGTH = 31,
    parameter int POSITION_BITS   = 48,
    parameter int WINDOW_BITS     = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ske_pkg::ske_cfg_t         cfg,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                base_code,
    input  logic                      last_base,
    input  logic                      buf_ready,
    output logic                      push,
    output ske_pkg::ske_result_t      result
);
    import ske_pkg::*;

    localparam int SW    = 2 * MAX_KMER_LENGTH;
    localparam int CMP_W = ((WINDOW_BITS > WIN_W) ? WINDOW_BITS : WIN_W) + 1;
    localparam int OFF_W = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;
    localparam logic [KLEN_W-1:0] KMAX = KLEN_W'(MAX_KMER_LENGTH);

    logic                     in_valid_reg;
    logic [1:0]               code_reg;
    logic                     last_reg;
    logic [SW-1:0]            shift_reg;
    logic [SW-1:0]            shift_next;
    logic [SEEN_W-1:0]        seen_reg;
    logic [SEEN_W-1:0]        seen_next;
    logic [WINDOW_BITS-1:0]   phase_reg;
    logic [WINDOW_BITS-1:0]   phase_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;

    logic                     advance;
    logic [KLEN_W-1:0]        k_eff;
    logic [WIN_W-1:0]         w_eff;
    logic [SW+1:0]            shift_cat;
    logic [SW-1:0]            shift_new;
    logic [SEEN_W-1:0]        seen_new;
    logic                     full;
    logic [SW-1:0]            kmask;
    logic [CMP_W-1:0]         phase_inc;
    logic [OFF_W-1:0]         offset_full;

    assign advance  = in_valid_reg && buf_ready;
    assign in_stall = in_valid_reg && !buf_ready;

    always_comb
    begin
        if (cfg.kmer_length == '0)
        begin
            k_eff = KLEN_W'(1);
        end
        else if (cfg.kmer_length > KMAX)
        begin
            k_eff = KMAX;
        end
        else
        begin
            k_eff = cfg.kmer_length;
        end
        w_eff = (cfg.sample_window == '0) ? WIN_W'(1) : cfg.sample_window;

        shift_cat = {shift_reg, code_reg};
        shift_new = shift_cat[SW-1:0];
        seen_new  = (seen_reg == '1) ? seen_reg : seen_reg + SEEN_W'(1);
        full      = seen_new >= SEEN_W'(k_eff);

        for (int i = 0; i < SW; i++)
        begin
            kmask[i] = 7'(i) < {1'b0, k_eff, 1'b0};
        end

        offset_full = OFF_W'(pos_reg) - OFF_W'(k_eff) + OFF_W'(1);
        result.kmer_value  = VALUE_W'(shift_new & kmask);
        result.kmer_offset = offset_full[OFFSET_W-1:0];
        push = advance && full && (phase_reg == '0);

        phase_inc  = CMP_W'(phase_reg) + CMP_W'(1);
        phase_next = phase_reg;
        if (full)
        begin
            phase_next = (phase_inc >= CMP_W'(w_eff)) ? '0 : phase_inc[WINDOW_BITS-1:0];
        end
        pos_next   = (pos_reg == '1) ? pos_reg : pos_reg + POSITION_BITS'(1);
        shift_next = shift_new;
        seen_next  = seen_new;
        if (last_reg)
        begin
            shift_next = '0;
            seen_next  = '0;
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            shift_reg    <= '0;
            seen_reg     <= '0;
            phase_reg    <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                shift_reg <= shift_next;
                seen_reg  <= seen_next;
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            code_reg <= base_code;
            last_reg <= last_base;
        end
    end

endmodule

/* hw/rtl/ske_out_buf.sv */
// ----------------------------------------------------------------------------
// Sampled k-mer extractor result buffer
// Two-entry result queue that decouples the core from a stalled consumer.
// ----------------------------------------------------------------------------
module ske_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ske_pkg::ske_result_t push_data,
    output logic                 buf_ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ske_pkg::ske_result_t out_data
);
    import ske_pkg::*;

    ske_result_t entry_reg [2];
    logic        head_reg;
    logic        head_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;
    logic        wr_idx;

    assign out_valid = count_reg != 2'd0;
    assign buf_ready = count_reg != 2'd2;
    assign pop       = out_valid && !out_stall;
    assign wr_idx    = head_reg ^ count_reg[0];
    assign out_data  = entry_reg[head_reg];

    always_comb
    begin
        head_next  = pop ? !head_reg : head_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_idx] <= push_data;
        end
    end

endmodule

/* dv/tb_sampled_kmer_extractor_top.sv */
// ----------------------------------------------------------------------------
// Sampled k-mer extractor testbench
// Streams random and directed base sequences through the block under varying
// k-mer lengths and sample windows. An in-bench tracker predicts every sampled
// k-mer and its global offset, and each result request is checked against the
// oldest prediction. Input gaps and result stalls are drawn at random; one
// long hold on the result side makes the block back up into its input.
// ----------------------------------------------------------------------------
module tb_sampled_kmer_extractor_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ske_pkg::*;

    localparam int ITEM_TARGET    = 1350;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_K          = 31;
    localparam int PRINT_CAP      = 40;

    class kmer_sample_tracker;
        logic [KLEN_W-1:0]   kmer_length;
        logic [WIN_W-1:0]    sample_window;
        logic [VALUE_W-1:0]  base_shift;
        logic [SEEN_W-1:0]   bases_seen;
        logic [WIN_W-1:0]    window_phase;
        logic [OFFSET_W-1:0] global_position;
        ske_result_t         due_kmers[$];
        int                  mismatch_count;

        function new();
            kmer_length     = KLEN_RESET;
            sample_window   = WIN_RESET;
            base_shift      = '0;
            bases_seen      = '0;
            window_phase    = '0;
            global_position = '0;
            mismatch_count  = 0;
        endfunction

        task report_mismatch(string what);
            if (mismatch_count < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, what);
            mismatch_count++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_KMER_LENGTH)
                kmer_length = data[KLEN_W-1:0];
            else if (index == REG_SAMPLE_WINDOW)
                sample_window = data[WIN_W-1:0];
        endfunction

        function void take_base(logic [1:0] code, logic last);
            int                  k;
            int                  w;
            logic [63:0]         kmask;
            logic [OFFSET_W-1:0] cur;
            ske_result_t         kmer;
            k   = (kmer_length == 0) ? 1 : int'(kmer_length);
            k   = (k > MAX_K) ? MAX_K : k;
            w   = (sample_window == 0) ? 1 : int'(sample_window);
            cur = global_position;
            base_shift = {base_shift[VALUE_W-3:0], code};
            if (bases_seen != '1)
                bases_seen = bases_seen + 1'b1;
            if (int'(bases_seen) >= k)
            begin
                if (window_phase == 0)
                begin
                    kmask            = (64'd1 << (2 * k)) - 64'd1;
                    kmer.kmer_value  = base_shift & kmask[VALUE_W-1:0];
                    kmer.kmer_offset = cur - OFFSET_W'(k - 1);
                    due_kmers.push_back(kmer);
                end
                if (int'(window_phase) + 1 >= w)
                    window_phase = '0;
                else
                    window_phase = window_phase + 1'b1;
            end
            if (global_position != '1)
                global_position = global_position + 1'b1;
            if (last)
            begin
                base_shift   = '0;
                bases_seen   = '0;
                window_phase = '0;
            end
        endfunction

        task match_kmer(logic [VALUE_W-1:0] value, logic [OFFSET_W-1:0] offset);
            ske_result_t want;
            if (due_kmers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected k-mer %h at offset %0d", value, offset));
            end
            else
            begin
                want = due_kmers.pop_front();
                if (value !== want.kmer_value)
                    report_mismatch($sformatf("kmer_value %h, expected %h",
                                              value, want.kmer_value));
                if (offset !== want.kmer_offset)
                    report_mismatch($sformatf("kmer_offset %0d, expected %0d",
                                              offset, want.kmer_offset));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            base_code;
    logic                  last_base;
    logic                  out_valid;
    logic                  out_stall;
    logic [VALUE_W-1:0]    kmer_value;
    logic [OFFSET_W-1:0]   kmer_offset;

    kmer_sample_tracker sampler = new();
    int                 bases_sent = 0;
    int                 send_mode = 0;
    bit                 hold_results = 1'b0;

    sampled_kmer_extractor_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .base_code   (base_code),
        .last_base   (last_base),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kmer_value  (kmer_value),
        .kmer_offset (kmer_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return int'($urandom_range(0, 17));
            default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 17)) : 0;
        endcase
    endfunction

    task automatic configure(logic [CFG_DATA_W-1:0] klen_data, logic [CFG_DATA_W-1:0] win_data);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_KMER_LENGTH;
        cfg_data  <= klen_data;
        @(posedge clk);
        cfg_index <= REG_SAMPLE_WINDOW;
        cfg_data  <= win_data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_base(logic [1:0] code, logic last, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        base_code <= code;
        last_base <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bases_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sampler.due_kmers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sampler.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sampler.take_base(base_code, last_base);
            if (out_valid && !out_stall)
                sampler.match_kmer(kmer_value, kmer_offset);
        end
    end

    initial
    begin : result_side
        int recv_mode;
        int n;
        recv_mode = 0;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_mode = int'($urandom_range(0, 2));
            if (hold_results)
            begin
                hold_results = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                n = draw_wait(recv_mode);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid && !hold_results) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int               i;
        int               s;
        int               nseq;
        int               len;
        int               keff;
        logic [KLEN_W-1:0] klen;
        logic [WIN_W-1:0]  win;
        bit               open_end;
        logic             last;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        base_code <= 2'd0;
        last_base <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_KMER_LENGTH;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length and zero window both act as one; upper data bits are ignored.
        configure({5'b11111, 5'd0}, 10'd0);
        send_base(2'd0, 1'b0, 0);
        send_base(2'd1, 1'b0, 0);
        send_base(2'd2, 1'b0, 0);
        send_base(2'd3, 1'b1, 0);
        drain();

        // The window shrinks mid-sequence so that the phase wraps, then a short sequence.
        configure(10'd2, 10'd3);
        for (i = 0; i < 9; i++)
            send_base(2'(i), 1'b0, draw_wait(1));
        drain();
        configure(10'd2, 10'd2);
        send_base(2'd3, 1'b0, draw_wait(1));
        send_base(2'd0, 1'b0, draw_wait(1));
        send_base(2'd1, 1'b1, draw_wait(1));
        send_base(2'd2, 1'b1, draw_wait(1));
        drain();

        // Results are held back long enough for the block to stall its input.
        configure(10'd1, 10'd1);
        hold_results = 1'b1;
        repeat (40)
            send_base(2'($urandom_range(0, 3)), 1'($urandom_range(0, 7) == 0), 0);
        drain();

        while (bases_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       klen = 5'd0;
                1:       klen = 5'd31;
                2:       klen = 5'd1;
                3, 4, 5, 6, 7: klen = 5'($urandom_range(2, 8));
                default: klen = 5'($urandom_range(1, 31));
            endcase
            case ($urandom_range(0, 9))
                0:       win = 10'd0;
                1:       win = 10'd1023;
                2:       win = 10'($urandom_range(1, 1023));
                3, 4, 5: win = 10'd1;
                default: win = 10'($urandom_range(2, 5));
            endcase
            configure({5'($urandom_range(0, 31)), klen}, win);
            keff      = (klen == 0) ? 1 : int'(klen);
            send_mode = int'($urandom_range(0, 2));
            nseq      = int'($urandom_range(1, 5));
            open_end  = ($urandom_range(0, 3) == 0);
            for (s = 0; s < nseq; s++)
            begin
                case ($urandom_range(0, 9))
                    0:       len = int'($urandom_range(1, (keff > 1) ? keff - 1 : 1));
                    1:       len = int'($urandom_range(64, 100));
                    default: len = int'($urandom_range(keff, keff + 24));
                endcase
                for (i = 0; i < len; i++)
                begin
                    last = (i == len - 1) ? !(open_end && s == nseq - 1)
                                          : ($urandom_range(0, 39) == 0);
                    send_base(2'($urandom_range(0, 3)), last, draw_wait(send_mode));
                end
            end
            drain();
        end

        drain();
        if (sampler.due_kmers.size() != 0)
            sampler.report_mismatch($sformatf("%0d k-mers never arrived",
                                              sampler.due_kmers.size()));
        if (sampler.mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
